[rtl/timestamp_difference_assert.svh]
// assertion macros for the timestamp difference block
// no dependencies; included by the port checker
`ifndef TIMESTAMP_DIFFERENCE_ASSERT_SVH
`define TIMESTAMP_DIFFERENCE_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define TSD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define TSD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/tsd_pkg.sv]
// shared types, constants and calendar functions for the timestamp difference block
// no dependencies; imported by every module of the block
package tsd_pkg;

   // status codes
   localparam logic [3:0] ST_OK         = 4'd0;
   localparam logic [3:0] ST_BAD_YEAR   = 4'd1;
   localparam logic [3:0] ST_BAD_MONTH  = 4'd2;
   localparam logic [3:0] ST_BAD_DAY    = 4'd3;
   localparam logic [3:0] ST_BAD_HOUR   = 4'd4;
   localparam logic [3:0] ST_BAD_MINUTE = 4'd5;
   localparam logic [3:0] ST_BAD_SECOND = 4'd6;
   localparam logic [3:0] ST_SECOND_OFS = 4'd6;
   localparam logic [3:0] ST_MAX        = 4'd12;

   // calendar radices
   localparam logic [5:0]  SEC_PER_MIN   = 6'd60;
   localparam logic [4:0]  HOUR_PER_DAY  = 5'd24;
   localparam logic [8:0]  DAY_PER_YEAR  = 9'd365;
   localparam logic [3:0]  MONTHS        = 4'd12;
   localparam logic [4:0]  LAST_HOUR     = 5'd23;
   localparam logic [5:0]  LAST_MINUTE   = 6'd59;
   localparam logic [16:0] SEC_PER_DAY   = 17'd86400;
   localparam logic [11:0] SEC_PER_HOUR  = 12'd3600;
   localparam logic [24:0] SEC_PER_YEAR  = 25'd31536000;

   // timestamp as it arrives on the input
   typedef struct packed {
      logic signed [14:0] year;
      logic [3:0]         month;
      logic [4:0]         day;
      logic [4:0]         hour;
      logic [5:0]         minute;
      logic [5:0]         second;
   } raw_stamp_type;

   // timestamp in mixed radix: year count, day of year, time of day
   typedef struct packed {
      logic signed [14:0] year;
      logic [8:0]         doy;
      logic [4:0]         hour;
      logic [5:0]         minute;
      logic [5:0]         second;
   } norm_stamp_type;

   typedef struct packed {
      logic [3:0]     status;
      norm_stamp_type a;
      norm_stamp_type b;
   } dec_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [14:0] years;
      logic [8:0]  days;
      logic [4:0]  hours;
      logic [5:0]  minutes;
      logic [5:0]  seconds;
   } diff_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [39:0] total;
      logic [14:0] years;
      logic [8:0]  days;
      logic [4:0]  hours;
      logic [5:0]  minutes;
      logic [5:0]  seconds;
   } rsp_type;

   // days in each month, february fixed at 28
   function automatic logic [4:0] month_len(input logic [3:0] month);
      logic [4:0] len;
      unique case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
         4'd2:                                      len = 5'd28;
         default:                                   len = 5'd0;
      endcase
      return len;
   endfunction

   // days of the year before the first of each month
   function automatic logic [8:0] days_before(input logic [3:0] month);
      logic [8:0] days;
      unique case (month)
         4'd2:    days = 9'd31;
         4'd3:    days = 9'd59;
         4'd4:    days = 9'd90;
         4'd5:    days = 9'd120;
         4'd6:    days = 9'd151;
         4'd7:    days = 9'd181;
         4'd8:    days = 9'd212;
         4'd9:    days = 9'd243;
         4'd10:   days = 9'd273;
         4'd11:   days = 9'd304;
         4'd12:   days = 9'd334;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

   // first bad field of a timestamp, in checking order
   function automatic logic [3:0] check_stamp(input raw_stamp_type s);
      logic [3:0] code;
      priority if (s.year == 15'sd0)                            code = ST_BAD_YEAR;
      else if (s.month == 4'd0 || s.month > MONTHS)             code = ST_BAD_MONTH;
      else if (s.day == 5'd0 || s.day > month_len(s.month))     code = ST_BAD_DAY;
      else if (s.hour > LAST_HOUR)                              code = ST_BAD_HOUR;
      else if (s.minute > LAST_MINUTE)                          code = ST_BAD_MINUTE;
      else if (s.second > LAST_MINUTE)                          code = ST_BAD_SECOND;
      else                                                      code = ST_OK;
      return code;
   endfunction

   // year -1 runs straight into year 1, so positive years shift down by one
   function automatic norm_stamp_type normalise(input raw_stamp_type s);
      norm_stamp_type n;
      n.year   = s.year[14] ? s.year : s.year - 15'sd1;
      n.doy    = days_before(s.month) + {4'd0, s.day} - 9'd1;
      n.hour   = s.hour;
      n.minute = s.minute;
      n.second = s.second;
      return n;
   endfunction

endpackage

[rtl/tsd_decode.sv]
// first stage: field checks, status code and mixed-radix form of both timestamps
// depends on tsd_pkg
module tsd_decode (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  tsd_pkg::raw_stamp_type stamp_a,
   input  tsd_pkg::raw_stamp_type stamp_b,
   output logic                  out_valid,
   input  logic                  out_ready,
   output tsd_pkg::dec_type      out_data
);
   import tsd_pkg::*;

   logic       valid_ff;
   dec_type    data_ff;
   dec_type    data_in;
   logic [3:0] code_a;
   logic [3:0] code_b;

   assign in_ready = !valid_ff || out_ready;

   // status and normalised stamps; invalid items carry zero stamps
   always_comb begin
      code_a = check_stamp(stamp_a);
      code_b = check_stamp(stamp_b);
      priority if (code_a != ST_OK) begin
         data_in.status = code_a;
      end else if (code_b != ST_OK) begin
         data_in.status = code_b + ST_SECOND_OFS;
      end else begin
         data_in.status = ST_OK;
      end
      if (data_in.status == ST_OK) begin
         data_in.a = normalise(stamp_a);
         data_in.b = normalise(stamp_b);
      end else begin
         data_in.a = '0;
         data_in.b = '0;
      end
   end

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[rtl/tsd_borrow.sv]
// second and third stages: order the stamps, then subtract field by field with borrows
// depends on tsd_pkg
module tsd_borrow (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  tsd_pkg::dec_type  in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output tsd_pkg::diff_type out_data
);
   import tsd_pkg::*;

   logic           ord_valid_ff;
   logic           ord_ready;
   logic [3:0]     status_ff;
   norm_stamp_type hi_ff;
   norm_stamp_type lo_ff;
   norm_stamp_type hi_in;
   norm_stamp_type lo_in;
   logic [40:0]    key_a;
   logic [40:0]    key_b;

   logic           sub_valid_ff;
   diff_type       diff_ff;
   diff_type       diff_in;
   logic           bs;
   logic           bm;
   logic           bh;
   logic           bd;

   assign in_ready  = !ord_valid_ff || ord_ready;
   assign ord_ready = !sub_valid_ff || out_ready;

   // ordering: sign-flipped year then the lower fields compare as one unsigned key
   always_comb begin
      key_a = {~in_data.a.year[14], in_data.a.year[13:0], in_data.a.doy,
               in_data.a.hour, in_data.a.minute, in_data.a.second};
      key_b = {~in_data.b.year[14], in_data.b.year[13:0], in_data.b.doy,
               in_data.b.hour, in_data.b.minute, in_data.b.second};
      if (key_a >= key_b) begin
         hi_in = in_data.a;
         lo_in = in_data.b;
      end else begin
         hi_in = in_data.b;
         lo_in = in_data.a;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ord_valid_ff <= 1'b0;
      end else if (in_ready) begin
         ord_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         status_ff <= in_data.status;
         hi_ff     <= hi_in;
         lo_ff     <= lo_in;
      end
   end

   // mixed-radix subtraction; each digit wraps back into range on a borrow
   always_comb begin
      bs = hi_ff.second < lo_ff.second;
      bm = {1'b0, hi_ff.minute} < {1'b0, lo_ff.minute} + {6'd0, bs};
      bh = {1'b0, hi_ff.hour} < {1'b0, lo_ff.hour} + {5'd0, bm};
      bd = {1'b0, hi_ff.doy} < {1'b0, lo_ff.doy} + {9'd0, bh};
      diff_in.status  = status_ff;
      diff_in.seconds = hi_ff.second - lo_ff.second + (bs ? SEC_PER_MIN : 6'd0);
      diff_in.minutes = hi_ff.minute - lo_ff.minute - {5'd0, bs}
                        + (bm ? SEC_PER_MIN : 6'd0);
      diff_in.hours   = hi_ff.hour - lo_ff.hour - {4'd0, bm}
                        + (bh ? HOUR_PER_DAY : 5'd0);
      diff_in.days    = hi_ff.doy - lo_ff.doy - {8'd0, bh}
                        + (bd ? DAY_PER_YEAR : 9'd0);
      diff_in.years   = 15'(hi_ff.year - lo_ff.year) - {14'd0, bd};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_valid_ff <= 1'b0;
      end else if (ord_ready) begin
         sub_valid_ff <= ord_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ord_ready && ord_valid_ff) begin
         diff_ff <= diff_in;
      end
   end

   assign out_valid = sub_valid_ff;
   assign out_data  = diff_ff;

endmodule

[rtl/tsd_total.sv]
// fourth and fifth stages: scale each digit to seconds, then sum into the total
// depends on tsd_pkg
module tsd_total (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  tsd_pkg::diff_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output tsd_pkg::rsp_type  out_data
);
   import tsd_pkg::*;

   logic        mul_valid_ff;
   logic        mul_ready;
   diff_type    digits_ff;
   logic [39:0] py_ff;
   logic [39:0] py_in;
   logic [24:0] pd_ff;
   logic [24:0] pd_in;
   logic [16:0] phms_ff;
   logic [16:0] phms_in;

   logic        sum_valid_ff;
   rsp_type     rsp_ff;
   rsp_type     rsp_in;

   assign in_ready  = !mul_valid_ff || mul_ready;
   assign mul_ready = !sum_valid_ff || out_ready;

   // constant products for years and days, with hours, minutes and seconds folded into one term
   always_comb begin
      py_in   = {25'd0, in_data.years} * {15'd0, SEC_PER_YEAR};
      pd_in   = {16'd0, in_data.days} * {8'd0, SEC_PER_DAY};
      phms_in = {12'd0, in_data.hours} * {5'd0, SEC_PER_HOUR}
                + {11'd0, in_data.minutes} * {11'd0, SEC_PER_MIN}
                + {11'd0, in_data.seconds};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (in_ready) begin
         mul_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         digits_ff <= in_data;
         py_ff     <= py_in;
         pd_ff     <= pd_in;
         phms_ff   <= phms_in;
      end
   end

   // final sum and output register
   always_comb begin
      rsp_in.status  = digits_ff.status;
      rsp_in.total   = py_ff + {15'd0, pd_ff} + {23'd0, phms_ff};
      rsp_in.years   = digits_ff.years;
      rsp_in.days    = digits_ff.days;
      rsp_in.hours   = digits_ff.hours;
      rsp_in.minutes = digits_ff.minutes;
      rsp_in.seconds = digits_ff.seconds;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
      end else if (mul_ready) begin
         sum_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mul_ready && mul_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = sum_valid_ff;
   assign out_data  = rsp_ff;

endmodule

[rtl/timestamp_difference.sv]
// Timestamp difference, 365-day calendar with February fixed at 28 days.
// One request transfer carries two timestamps (signed year with no year
// zero, month, day, hour, minute, second); one response transfer returns a
// status code, the absolute difference in seconds and that difference split
// into years, days, hours, minutes and seconds. A nonzero status names the
// first bad field (first timestamp before second) and zeroes the rest.
// Five register stages: decode and check, order, borrow subtraction,
// constant multiplies, final sum. One pair is taken every cycle while the
// response side keeps up.
// Each stage holds its item until the next stage has room, so a stalled
// receiver fills the pipeline from the output backwards and req_tready
// falls only once all five stages hold an item; nothing is dropped or
// repeated. Reset clears every stage valid bit; no memory needs clearing.
// depends on tsd_pkg, tsd_decode, tsd_borrow, tsd_total
module timestamp_difference (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // first_year, first_month, first_day, first_hour, first_minute,
   // first_second, second_year, second_month, second_day, second_hour,
   // second_minute, second_sec, zero fill
   input  logic [87:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status, total_difference, diff_years, diff_days, diff_hours,
   // diff_minutes, diff_seconds, zero fill
   output logic [87:0] rsp_tdata
);
   import tsd_pkg::*;

   raw_stamp_type stamp_a;
   raw_stamp_type stamp_b;
   dec_type       dec_data;
   logic          dec_valid;
   logic          dec_ready;
   diff_type      diff_data;
   logic          diff_valid;
   logic          diff_ready;
   rsp_type       rsp_data;

   // unpack request fields
   always_comb begin
      stamp_a.year   = req_tdata[14:0];
      stamp_a.month  = req_tdata[18:15];
      stamp_a.day    = req_tdata[23:19];
      stamp_a.hour   = req_tdata[28:24];
      stamp_a.minute = req_tdata[34:29];
      stamp_a.second = req_tdata[40:35];
      stamp_b.year   = req_tdata[55:41];
      stamp_b.month  = req_tdata[59:56];
      stamp_b.day    = req_tdata[64:60];
      stamp_b.hour   = req_tdata[69:65];
      stamp_b.minute = req_tdata[75:70];
      stamp_b.second = req_tdata[81:76];
   end

   tsd_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .stamp_a   (stamp_a),
      .stamp_b   (stamp_b),
      .out_valid (dec_valid),
      .out_ready (dec_ready),
      .out_data  (dec_data)
   );

   tsd_borrow u_borrow (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_ready  (dec_ready),
      .in_data   (dec_data),
      .out_valid (diff_valid),
      .out_ready (diff_ready),
      .out_data  (diff_data)
   );

   tsd_total u_total (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (diff_valid),
      .in_ready  (diff_ready),
      .in_data   (diff_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_data)
   );

   // pack response fields
   assign rsp_tdata = {3'd0, rsp_data.seconds, rsp_data.minutes, rsp_data.hours,
                       rsp_data.days, rsp_data.years, rsp_data.total, rsp_data.status};

endmodule

[rtl/tsd_checker.sv]
// port checker for the timestamp difference block, bound to the top level
// depends on tsd_pkg and timestamp_difference_assert.svh
`include "timestamp_difference_assert.svh"

module tsd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [87:0] rsp_tdata
);
   import tsd_pkg::*;

   // a stalled response holds
   `TSD_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata), "response changed while stalled")

   // no response straight after reset
   `TSD_ASSERT_NOW(a_reset_empty, $fell(reset),
      !rsp_tvalid, "response valid straight after reset")

   // status codes stay within range
   `TSD_ASSERT_NOW(a_status_range, rsp_tvalid, rsp_tdata[3:0] <= ST_MAX,
      "status code out of range")

   // bad timestamps carry an all-zero difference
   `TSD_ASSERT_NOW(a_bad_zero, rsp_tvalid && rsp_tdata[3:0] != ST_OK,
      rsp_tdata[87:4] == 84'd0, "difference not zero on bad status")

   // split digits stay below their radix
   `TSD_ASSERT_NOW(a_digit_range, rsp_tvalid,
      rsp_tdata[84:79] < SEC_PER_MIN && rsp_tdata[78:73] < SEC_PER_MIN &&
      rsp_tdata[72:68] < HOUR_PER_DAY && rsp_tdata[67:59] < DAY_PER_YEAR,
      "split digit out of range")

endmodule

bind timestamp_difference tsd_checker u_tsd_checker (.*);
